>>> hdl/ivtl_pkg.sv
// ----------------------------------------------------------------------------
// ivtl_pkg: shared types and constants of the icosphere vertex tree locator
// Widths, command and register codes, state types and the table port bundles.
// ----------------------------------------------------------------------------
package ivtl_pkg;

    localparam int COORD_W    = 16;
    localparam int SUM_W      = COORD_W + 1;
    localparam int MAX_FACES  = 32;
    localparam int FACE_W     = 5;
    localparam int VTX_W      = 6;
    localparam int MAX_LEVELS = 16;
    localparam int LVL_W      = 5;
    localparam int CODE_W     = 31;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam int FC_W       = 3 * VTX_W;

    localparam logic [CFG_IDX_W-1:0] CFG_LEVELS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FACE_COUNT = 2'd1;

    typedef enum logic [1:0] {
        CMD_LOAD_DIR     = 2'd0,
        CMD_LOAD_CORNERS = 2'd1,
        CMD_LOAD_VERTEX  = 2'd2,
        CMD_LOCATE       = 2'd3
    } cmd_t;

    typedef logic [2:0][COORD_W-1:0] vec_t;
    typedef logic [2:0][SUM_W-1:0]   sum_vec_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NDIR_GO,
        ST_NDIR_WAIT,
        ST_SC_RD,
        ST_SC_MUL,
        ST_SC_CMP,
        ST_FC_RD,
        ST_VX,
        ST_DIST,
        ST_PICK,
        ST_N1_GO,
        ST_N1_WAIT,
        ST_N2_GO,
        ST_N2_WAIT,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        N_IDLE,
        N_SQ,
        N_CHK,
        N_SQRT,
        N_DLOAD,
        N_DIV,
        N_STORE,
        N_DONE
    } norm_state_t;

    typedef struct packed {
        logic              fd_we;
        logic [FACE_W-1:0] fd_waddr;
        vec_t              fd_wdata;
        logic [FACE_W-1:0] fd_raddr;
        logic              fc_we;
        logic [FACE_W-1:0] fc_waddr;
        logic [FC_W-1:0]   fc_wdata;
        logic [FACE_W-1:0] fc_raddr;
        logic              vx_we;
        logic [VTX_W-1:0]  vx_waddr;
        vec_t              vx_wdata;
        logic [VTX_W-1:0]  vx_raddr;
    } tbl_req_t;

    typedef struct packed {
        vec_t            fd_rdata;
        logic [FC_W-1:0] fc_rdata;
        vec_t            vx_rdata;
    } tbl_rsp_t;

endpackage

>>> hdl/icosphere_vertex_tree_locate.sv
// ----------------------------------------------------------------------------
// icosphere_vertex_tree_locate: point to base-3 icosphere tree code
// Table loads, face scan and level-by-level descent toward the nearest corner.
// ----------------------------------------------------------------------------
// A face direction load runs one normalization. A locate scans each face in
// use, fetches the corners of the best face, and then descends level by level,
// spending almost all of each level in its two normalizations, which share one
// iterative square root and divider. A new beat is taken only once the
// previous one has finished; a result may still wait in the output register.
module icosphere_vertex_tree_locate (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_cmd,
    input  logic [5:0]                          s_index,
    input  logic signed [15:0]                  s_coord_x,
    input  logic signed [15:0]                  s_coord_y,
    input  logic signed [15:0]                  s_coord_z,
    input  logic [5:0]                          s_corner_first,
    input  logic [5:0]                          s_corner_second,
    input  logic [5:0]                          s_corner_third,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [ivtl_pkg::CODE_W-1:0]         m_tree_code,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ivtl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ivtl_pkg::CFG_DATA_W-1:0]     cfg_data
);

    ivtl_pkg::state_t state_reg, state_next;

    logic [4:0]                     levels_reg;
    logic [5:0]                     face_count_reg;
    logic [5:0]                     nf_reg;
    logic [ivtl_pkg::LVL_W-1:0]     lv_reg;
    logic [5:0]                     idx_reg;
    ivtl_pkg::vec_t                 x_reg;
    logic [5:0]                     face_cnt_reg;
    logic [ivtl_pkg::FACE_W-1:0]    best_reg;
    logic signed [33:0]             best_dot_reg;
    logic signed [33:0]             dot_reg;
    logic signed [33:0]             prod_reg;
    logic [1:0]                     k_reg;
    logic [1:0]                     j_reg;
    logic [1:0]                     tag_reg;
    logic [3:0]                     step_reg;
    ivtl_pkg::vec_t                 corner_reg [3];
    logic [35:0]                    dist_reg [3];
    logic [1:0]                     near_reg;
    logic [ivtl_pkg::CODE_W-1:0]    code_reg;
    logic [ivtl_pkg::LVL_W-1:0]     level_cnt_reg;
    logic                           m_valid_reg;
    logic [ivtl_pkg::CODE_W-1:0]    m_code_reg;

    ivtl_pkg::tbl_req_t             req;
    ivtl_pkg::tbl_rsp_t             rsp;
    logic                           norm_start;
    ivtl_pkg::sum_vec_t             norm_vec;
    logic                           norm_done;
    ivtl_pkg::vec_t                 norm_res;

    logic                           s_fire;
    logic [1:0]                     kk;
    logic [1:0]                     other1;
    logic [1:0]                     other2;
    logic [1:0]                     pick;
    logic signed [16:0]             diff;
    logic [5:0]                     nf_calc;
    logic [ivtl_pkg::LVL_W-1:0]     lv_calc;
    logic [ivtl_pkg::VTX_W-1:0]     vx_sel;

    ivtl_store u_store (
        .aclk (aclk),
        .req  (req),
        .rsp  (rsp)
    );

    ivtl_norm u_norm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (norm_start),
        .vec     (norm_vec),
        .done    (norm_done),
        .result  (norm_res)
    );

    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_tree_code = m_code_reg;
    assign kk        = (k_reg == 2'd3) ? 2'd0 : k_reg;
    assign other1    = (near_reg == 2'd0) ? 2'd1 : 2'd0;
    assign other2    = (near_reg == 2'd2) ? 2'd1 : 2'd2;
    assign diff      = 17'($signed(corner_reg[j_reg][kk])) - 17'($signed(x_reg[kk]));

    always_comb begin
        if (face_count_reg == 6'd0) begin
            nf_calc = 6'd1;
        end else if (face_count_reg > 6'(ivtl_pkg::MAX_FACES)) begin
            nf_calc = 6'(ivtl_pkg::MAX_FACES);
        end else begin
            nf_calc = face_count_reg;
        end
        lv_calc = (levels_reg > 5'(ivtl_pkg::MAX_LEVELS)) ? 5'(ivtl_pkg::MAX_LEVELS)
                                                         : levels_reg;
    end

    // Nearest corner; ties go to the earlier corner.
    always_comb begin
        if (dist_reg[0] <= dist_reg[1] && dist_reg[0] <= dist_reg[2]) begin
            pick = 2'd0;
        end else if (dist_reg[1] <= dist_reg[2]) begin
            pick = 2'd1;
        end else begin
            pick = 2'd2;
        end
    end

    always_comb begin
        unique case (step_reg[1:0])
            2'd0:    vx_sel = rsp.fc_rdata[5:0];
            2'd1:    vx_sel = rsp.fc_rdata[11:6];
            default: vx_sel = rsp.fc_rdata[17:12];
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ivtl_pkg::ST_IDLE: begin
                if (s_fire) begin
                    priority if (s_cmd == ivtl_pkg::CMD_LOAD_DIR) begin
                        state_next = ivtl_pkg::ST_NDIR_GO;
                    end else if (s_cmd == ivtl_pkg::CMD_LOCATE) begin
                        state_next = ivtl_pkg::ST_SC_RD;
                    end else begin
                        state_next = ivtl_pkg::ST_IDLE;
                    end
                end
            end
            ivtl_pkg::ST_NDIR_GO:   state_next = ivtl_pkg::ST_NDIR_WAIT;
            ivtl_pkg::ST_NDIR_WAIT: if (norm_done) state_next = ivtl_pkg::ST_IDLE;
            ivtl_pkg::ST_SC_RD:     state_next = ivtl_pkg::ST_SC_MUL;
            ivtl_pkg::ST_SC_MUL:    if (k_reg == 2'd3) state_next = ivtl_pkg::ST_SC_CMP;
            ivtl_pkg::ST_SC_CMP: begin
                state_next = (face_cnt_reg + 6'd1 == nf_reg) ? ivtl_pkg::ST_FC_RD
                                                             : ivtl_pkg::ST_SC_RD;
            end
            ivtl_pkg::ST_FC_RD:     state_next = ivtl_pkg::ST_VX;
            ivtl_pkg::ST_VX: begin
                if (step_reg == 4'd3) begin
                    state_next = (lv_reg == '0) ? ivtl_pkg::ST_DONE : ivtl_pkg::ST_DIST;
                end
            end
            ivtl_pkg::ST_DIST:      if (step_reg == 4'd9) state_next = ivtl_pkg::ST_PICK;
            ivtl_pkg::ST_PICK:      state_next = ivtl_pkg::ST_N1_GO;
            ivtl_pkg::ST_N1_GO:     state_next = ivtl_pkg::ST_N1_WAIT;
            ivtl_pkg::ST_N1_WAIT:   if (norm_done) state_next = ivtl_pkg::ST_N2_GO;
            ivtl_pkg::ST_N2_GO:     state_next = ivtl_pkg::ST_N2_WAIT;
            ivtl_pkg::ST_N2_WAIT: begin
                if (norm_done) begin
                    state_next = (level_cnt_reg + 5'd1 == lv_reg) ? ivtl_pkg::ST_DONE
                                                                  : ivtl_pkg::ST_DIST;
                end
            end
            ivtl_pkg::ST_DONE:      if (!m_valid_reg || m_ready) state_next = ivtl_pkg::ST_IDLE;
            default:                state_next = ivtl_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready      = (state_reg == ivtl_pkg::ST_IDLE);
        norm_start   = 1'b0;
        norm_vec     = '0;
        req          = '0;
        req.fd_raddr = face_cnt_reg[ivtl_pkg::FACE_W-1:0];
        req.fc_raddr = best_reg;
        req.vx_raddr = vx_sel;
        req.fd_waddr = idx_reg[ivtl_pkg::FACE_W-1:0];
        req.fd_wdata = norm_res;
        req.fc_waddr = s_index[ivtl_pkg::FACE_W-1:0];
        req.fc_wdata = {s_corner_third, s_corner_second, s_corner_first};
        req.vx_waddr = s_index;
        req.vx_wdata = {s_coord_z, s_coord_y, s_coord_x};
        unique case (state_reg)
            ivtl_pkg::ST_IDLE: begin
                req.fc_we = s_fire && (s_cmd == ivtl_pkg::CMD_LOAD_CORNERS) && !s_index[5];
                req.vx_we = s_fire && (s_cmd == ivtl_pkg::CMD_LOAD_VERTEX);
            end
            ivtl_pkg::ST_NDIR_GO: begin
                norm_start = 1'b1;
                for (int i = 0; i < 3; i++) begin
                    norm_vec[i] = 17'($signed(x_reg[i]));
                end
            end
            ivtl_pkg::ST_NDIR_WAIT: begin
                req.fd_we = norm_done && !idx_reg[5];
            end
            ivtl_pkg::ST_N1_GO: begin
                norm_start = 1'b1;
                for (int i = 0; i < 3; i++) begin
                    norm_vec[i] = 17'($signed(corner_reg[near_reg][i]))
                                + 17'($signed(corner_reg[other1][i]));
                end
            end
            ivtl_pkg::ST_N2_GO: begin
                norm_start = 1'b1;
                for (int i = 0; i < 3; i++) begin
                    norm_vec[i] = 17'($signed(corner_reg[near_reg][i]))
                                + 17'($signed(corner_reg[other2][i]));
                end
            end
            default: begin
                norm_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            levels_reg     <= '0;
            face_count_reg <= 6'd20;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == ivtl_pkg::CFG_LEVELS) begin
                levels_reg <= cfg_data[4:0];
            end else if (cfg_index == ivtl_pkg::CFG_FACE_COUNT) begin
                face_count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ivtl_pkg::ST_IDLE;
            m_valid_reg   <= 1'b0;
            code_reg      <= '0;
            level_cnt_reg <= '0;
            for (int i = 0; i < 3; i++) begin
                corner_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (state_reg == ivtl_pkg::ST_DONE && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ivtl_pkg::ST_IDLE: begin
                    if (s_fire) begin
                        idx_reg      <= s_index;
                        x_reg        <= {s_coord_z, s_coord_y, s_coord_x};
                        nf_reg       <= nf_calc;
                        lv_reg       <= lv_calc;
                        face_cnt_reg <= '0;
                        best_reg     <= '0;
                    end
                end
                ivtl_pkg::ST_SC_RD: begin
                    dot_reg <= '0;
                    k_reg   <= 2'd0;
                end
                ivtl_pkg::ST_SC_MUL: begin
                    prod_reg <= 34'($signed(rsp.fd_rdata[kk]) * $signed(x_reg[kk]));
                    if (k_reg != 2'd0) begin
                        dot_reg <= dot_reg + prod_reg;
                    end
                    k_reg <= k_reg + 2'd1;
                end
                ivtl_pkg::ST_SC_CMP: begin
                    if (face_cnt_reg == 6'd0 || dot_reg > best_dot_reg) begin
                        best_dot_reg <= dot_reg;
                        best_reg     <= face_cnt_reg[ivtl_pkg::FACE_W-1:0];
                    end
                    face_cnt_reg <= face_cnt_reg + 6'd1;
                    step_reg     <= '0;
                end
                ivtl_pkg::ST_VX: begin
                    // The read issued in the previous cycle belongs to the previous corner.
                    if (step_reg != 4'd0) begin
                        corner_reg[step_reg[1:0] - 2'd1] <= rsp.vx_rdata;
                    end
                    code_reg      <= ivtl_pkg::CODE_W'(best_reg);
                    level_cnt_reg <= '0;
                    if (step_reg == 4'd3) begin
                        step_reg <= '0;
                        j_reg    <= '0;
                        k_reg    <= '0;
                        for (int i = 0; i < 3; i++) begin
                            dist_reg[i] <= '0;
                        end
                    end else begin
                        step_reg <= step_reg + 4'd1;
                    end
                end
                ivtl_pkg::ST_DIST: begin
                    prod_reg <= 34'(diff * diff);
                    tag_reg  <= j_reg;
                    if (step_reg != 4'd0) begin
                        dist_reg[tag_reg] <= dist_reg[tag_reg] + 36'(prod_reg);
                    end
                    if (k_reg == 2'd2) begin
                        k_reg <= 2'd0;
                        j_reg <= (j_reg == 2'd2) ? 2'd0 : j_reg + 2'd1;
                    end else begin
                        k_reg <= k_reg + 2'd1;
                    end
                    step_reg <= step_reg + 4'd1;
                end
                ivtl_pkg::ST_PICK: begin
                    near_reg <= pick;
                    code_reg <= ivtl_pkg::CODE_W'({code_reg, 1'b0}) + code_reg
                              + ivtl_pkg::CODE_W'(pick);
                end
                ivtl_pkg::ST_N1_WAIT: begin
                    if (norm_done) begin
                        corner_reg[other1] <= norm_res;
                    end
                end
                ivtl_pkg::ST_N2_WAIT: begin
                    if (norm_done) begin
                        corner_reg[other2] <= norm_res;
                        level_cnt_reg      <= level_cnt_reg + 5'd1;
                        step_reg           <= '0;
                        j_reg              <= '0;
                        k_reg              <= '0;
                        for (int i = 0; i < 3; i++) begin
                            dist_reg[i] <= '0;
                        end
                    end
                end
                ivtl_pkg::ST_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_code_reg <= code_reg;
                    end
                end
                default: begin
                    k_reg <= k_reg;
                end
            endcase
        end
    end

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ivtl_pkg::ST_SC_CMP |-> face_cnt_reg < nf_reg)
        else $error("face scan ran past the faces in use");

    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ivtl_pkg::ST_DIST |-> level_cnt_reg < lv_reg)
        else $error("descent ran past the level count");

    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == ivtl_pkg::ST_DONE)
        else $error("result beat raised outside the finishing step");

    a_norm_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        norm_done |-> (state_reg == ivtl_pkg::ST_NDIR_WAIT
                       || state_reg == ivtl_pkg::ST_N1_WAIT
                       || state_reg == ivtl_pkg::ST_N2_WAIT))
        else $error("normalizer finished with no step waiting for it");

endmodule

>>> hdl/ivtl_store.sv
// ----------------------------------------------------------------------------
// ivtl_store: table memories
// Face direction, face corner and vertex memories, one write and one
// registered read port each.
// ----------------------------------------------------------------------------
module ivtl_store (
    input  logic              aclk,
    input  ivtl_pkg::tbl_req_t req,
    output ivtl_pkg::tbl_rsp_t rsp
);

    ivtl_pkg::vec_t                fd_mem [ivtl_pkg::MAX_FACES];
    logic [ivtl_pkg::FC_W-1:0]     fc_mem [ivtl_pkg::MAX_FACES];
    ivtl_pkg::vec_t                vx_mem [2**ivtl_pkg::VTX_W];

    ivtl_pkg::vec_t                fd_rd_reg;
    logic [ivtl_pkg::FC_W-1:0]     fc_rd_reg;
    ivtl_pkg::vec_t                vx_rd_reg;

    assign rsp = {fd_rd_reg, fc_rd_reg, vx_rd_reg};

    always_ff @(posedge aclk) begin
        if (req.fd_we) begin
            fd_mem[req.fd_waddr] <= req.fd_wdata;
        end
        fd_rd_reg <= fd_mem[req.fd_raddr];
    end

    always_ff @(posedge aclk) begin
        if (req.fc_we) begin
            fc_mem[req.fc_waddr] <= req.fc_wdata;
        end
        fc_rd_reg <= fc_mem[req.fc_raddr];
    end

    always_ff @(posedge aclk) begin
        if (req.vx_we) begin
            vx_mem[req.vx_waddr] <= req.vx_wdata;
        end
        vx_rd_reg <= vx_mem[req.vx_raddr];
    end

endmodule

>>> hdl/ivtl_norm.sv
// ----------------------------------------------------------------------------
// ivtl_norm: iterative vector normalizer
// Squared length by one shared squarer, a bit-serial square root and a
// restoring divider that rounds and saturates each component to Q2.14.
// ----------------------------------------------------------------------------
module ivtl_norm (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  ivtl_pkg::sum_vec_t  vec,
    output logic                done,
    output ivtl_pkg::vec_t      result
);

    localparam int LEN_W  = 2 * ivtl_pkg::SUM_W + 2;
    localparam int RAD_W  = 56;
    localparam int ROOT_W = 28;
    localparam int Q_W    = 17;
    localparam int NUM_W  = ivtl_pkg::SUM_W + 26;
    localparam int REM_W  = ROOT_W + 1;

    ivtl_pkg::norm_state_t state_reg, state_next;

    logic [2:0][ivtl_pkg::SUM_W-1:0] abs_reg;
    logic [2:0]                      neg_reg;
    logic [1:0]                      k_reg;
    logic [2*ivtl_pkg::SUM_W-1:0]    prod_reg;
    logic [LEN_W-1:0]                len_reg;
    logic [RAD_W-1:0]                n_reg;
    logic [RAD_W-1:0]                r_reg;
    logic [RAD_W-1:0]                bit_reg;
    logic [Q_W-1:0]                  num_reg;
    logic [REM_W-1:0]                rem_reg;
    logic [Q_W-1:0]                  q_reg;
    logic [4:0]                      cnt_reg;
    ivtl_pkg::vec_t                  res_reg;

    logic [1:0]                      kk;
    logic [RAD_W-1:0]                trial;
    logic [ROOT_W-1:0]               root;
    logic [REM_W-1:0]                divisor;
    logic [REM_W:0]                  shifted;
    logic [NUM_W-1:0]                num_full;
    logic [Q_W-1:0]                  q_sat;

    assign kk       = (k_reg == 2'd3) ? 2'd0 : k_reg;
    assign trial    = r_reg + bit_reg;
    assign root     = r_reg[ROOT_W-1:0];
    assign divisor  = {root, 1'b0};
    assign shifted  = {rem_reg, num_reg[Q_W-1]};
    assign num_full = {1'b0, abs_reg[kk], 25'b0} + NUM_W'(root);
    assign q_sat    = (q_reg > Q_W'(32767)) ? Q_W'(32767) : q_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ivtl_pkg::N_IDLE:  if (start) state_next = ivtl_pkg::N_SQ;
            ivtl_pkg::N_SQ:    if (k_reg == 2'd3) state_next = ivtl_pkg::N_CHK;
            ivtl_pkg::N_CHK: begin
                state_next = (len_reg == '0) ? ivtl_pkg::N_DONE : ivtl_pkg::N_SQRT;
            end
            ivtl_pkg::N_SQRT:  if (bit_reg[0]) state_next = ivtl_pkg::N_DLOAD;
            ivtl_pkg::N_DLOAD: state_next = ivtl_pkg::N_DIV;
            ivtl_pkg::N_DIV:   if (cnt_reg == 5'd1) state_next = ivtl_pkg::N_STORE;
            ivtl_pkg::N_STORE: begin
                state_next = (k_reg == 2'd2) ? ivtl_pkg::N_DONE : ivtl_pkg::N_DLOAD;
            end
            ivtl_pkg::N_DONE:  state_next = ivtl_pkg::N_IDLE;
            default:           state_next = ivtl_pkg::N_IDLE;
        endcase
    end

    always_comb begin
        done   = (state_reg == ivtl_pkg::N_DONE);
        result = res_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ivtl_pkg::N_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ivtl_pkg::N_IDLE: begin
                for (int i = 0; i < 3; i++) begin
                    neg_reg[i] <= vec[i][ivtl_pkg::SUM_W-1];
                    abs_reg[i] <= vec[i][ivtl_pkg::SUM_W-1] ? (~vec[i] + 1'b1) : vec[i];
                end
                k_reg   <= 2'd0;
                len_reg <= '0;
            end
            ivtl_pkg::N_SQ: begin
                prod_reg <= abs_reg[kk] * abs_reg[kk];
                if (k_reg != 2'd0) begin
                    len_reg <= len_reg + LEN_W'(prod_reg);
                end
                k_reg <= k_reg + 2'd1;
            end
            ivtl_pkg::N_CHK: begin
                res_reg <= '0;
                n_reg   <= RAD_W'({len_reg, 20'b0});
                r_reg   <= '0;
                bit_reg <= RAD_W'(1) << 54;
                k_reg   <= 2'd0;
            end
            ivtl_pkg::N_SQRT: begin
                if (n_reg >= trial) begin
                    n_reg <= n_reg - trial;
                    r_reg <= (r_reg >> 1) + bit_reg;
                end else begin
                    r_reg <= r_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            ivtl_pkg::N_DLOAD: begin
                rem_reg <= REM_W'(num_full[NUM_W-1:Q_W]);
                num_reg <= num_full[Q_W-1:0];
                q_reg   <= '0;
                cnt_reg <= 5'(Q_W);
            end
            ivtl_pkg::N_DIV: begin
                if (shifted >= {1'b0, divisor}) begin
                    rem_reg <= REM_W'(shifted - {1'b0, divisor});
                    q_reg   <= {q_reg[Q_W-2:0], 1'b1};
                end else begin
                    rem_reg <= shifted[REM_W-1:0];
                    q_reg   <= {q_reg[Q_W-2:0], 1'b0};
                end
                num_reg <= num_reg << 1;
                cnt_reg <= cnt_reg - 5'd1;
            end
            ivtl_pkg::N_STORE: begin
                res_reg[kk] <= neg_reg[kk] ? ivtl_pkg::COORD_W'(~q_sat + 1'b1)
                                           : ivtl_pkg::COORD_W'(q_sat);
                k_reg <= k_reg + 2'd1;
            end
            default: begin
                k_reg <= k_reg;
            end
        endcase
    end

endmodule
